### rtl/asm_pkg.sv
// Shared types and constants for the alarm set and match block.
`default_nettype none
package asm_pkg;

  localparam int FIELD_COUNT = 7;
  localparam int FIELD_W     = 7;

  typedef logic [FIELD_W-1:0] field_val_t;
  typedef logic [2:0]         field_idx_t;
  typedef logic [2:0]         cursor_t;
  typedef field_val_t [FIELD_COUNT-1:0] field_arr_t;

  typedef enum logic [1:0] {
    KIND_TIME   = 2'd0,
    KIND_SELECT = 2'd1,
    KIND_INC    = 2'd2,
    KIND_DEC    = 2'd3
  } kind_t;

  localparam cursor_t CUR_IDLE = 3'd0;

  // index 0 year, 1 month, 2 day, 3 weekday, 4 hour, 5 minute, 6 second
  localparam field_arr_t FIELD_MAX = {7'd59, 7'd59, 7'd23, 7'd6, 7'd31, 7'd12, 7'd99};
  localparam field_arr_t FIELD_MIN = {7'd0, 7'd0, 7'd0, 7'd0, 7'd1, 7'd1, 7'd0};

  typedef struct packed {
    kind_t      kind;
    logic [7:0] rtc_year_bcd;
    logic [7:0] rtc_month_bcd;
    logic [7:0] rtc_day_bcd;
    logic [7:0] rtc_weekday_raw;
    logic [7:0] rtc_hour_bcd;
    logic [7:0] rtc_minute_bcd;
    logic [7:0] rtc_second_bcd;
  } in_item_t;

  typedef struct packed {
    logic       alarm_on;
    cursor_t    cursor_field;
    field_val_t field_value;
    logic       time_matched;
  } out_item_t;

endpackage
`default_nettype wire

### rtl/asm_in_if.sv
// Input channel: valid/ready with one input item per beat.
`default_nettype none
interface asm_in_if
  import asm_pkg::*;
  ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

### rtl/asm_out_if.sv
// Result channel: valid/ready with one result item per beat.
`default_nettype none
interface asm_out_if
  import asm_pkg::*;
  ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

### rtl/asm_bcd_cmp.sv
// Decodes the clock sample bytes and compares them with the alarm fields.
`default_nettype none
module asm_bcd_cmp
  import asm_pkg::*;
(
  input  in_item_t   item,
  input  field_arr_t fields,
  output logic       time_eq
);

  function automatic field_val_t bcd_dec(input logic [7:0] b);
    field_val_t tens;
    tens = {4'd0, b[6:4]};
    return (tens << 3) + (tens << 1) + {3'd0, b[3:0]};
  endfunction

  field_arr_t t;

  always_comb begin
    t[0] = bcd_dec(item.rtc_year_bcd);
    t[1] = bcd_dec(item.rtc_month_bcd);
    t[2] = bcd_dec(item.rtc_day_bcd);
    t[3] = {4'd0, item.rtc_weekday_raw[2:0]};
    t[4] = bcd_dec(item.rtc_hour_bcd);
    t[5] = bcd_dec(item.rtc_minute_bcd);
    t[6] = bcd_dec(item.rtc_second_bcd);
  end

  assign time_eq = (t == fields);

endmodule
`default_nettype wire

### rtl/asm_field_step.sv
// Increment or decrement of one alarm field with per-field wrap limits.
`default_nettype none
module asm_field_step
  import asm_pkg::*;
(
  input  field_idx_t idx,
  input  logic       up,
  input  field_val_t cur,
  output field_val_t nxt
);

  field_val_t mx;
  field_val_t mn;
  logic [FIELD_W:0] inc;

  assign mx  = FIELD_MAX[idx];
  assign mn  = FIELD_MIN[idx];
  assign inc = {1'b0, cur} + {{FIELD_W{1'b0}}, 1'b1};

  always_comb begin
    if (up) begin
      nxt = (inc > {1'b0, mx}) ? mn : inc[FIELD_W-1:0];
    end else begin
      nxt = (cur <= mn) ? mx : cur - 7'd1;
    end
  end

endmodule
`default_nettype wire

### rtl/alarm_set_and_match_top.sv
// Alarm set and match block: edit cursor, alarm fields and time compare.
//
// Usage: items enter on in_ch (valid/ready); each item is a time sample,
// a select press, an increment press or a decrement press. Every accepted
// beat yields exactly one result beat on out_ch carrying the alarm latch,
// the edit cursor, the alarm value under the cursor and the match flag.
// Items pass through an input register, then a result register. Throughput:
// one item per cycle while out_ch.ready holds; the whole update
// is one pass of decode, compare and wrap logic between the two registers.
// State is updated as an item moves into the result register, so the
// next item sees it immediately.
// Reset (rst_n low, synchronous): all alarm fields zero, cursor idle,
// latch clear, both registers empty.
// Receiver stall: the result register holds its beat; the input register
// still takes one more item, then in_ch.ready drops until out_ch.ready
// returns. No beat is lost or repeated.
`default_nettype none
module alarm_set_and_match_top
  import asm_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  asm_in_if.sink     in_ch,
  asm_out_if.source  out_ch
);

  logic       in_v_r;
  in_item_t   in_data_r;
  logic       out_v_r;
  out_item_t  out_data_r;

  field_arr_t fields_r;
  cursor_t    cursor_r;
  logic       latch_r;

  field_arr_t fields_nxt;
  cursor_t    cursor_nxt;
  logic       latch_nxt;
  logic       matched;
  out_item_t  res_nxt;

  logic       out_free;
  logic       fire;
  logic       in_acc;
  logic       time_eq;
  field_idx_t sel_idx;
  field_idx_t out_idx;
  field_val_t step_val;

  assign out_free    = !out_v_r || out_ch.ready;
  assign fire        = in_v_r && out_free;
  assign in_ch.ready = !in_v_r || out_free;
  assign in_acc      = in_ch.valid && in_ch.ready;

  assign out_ch.valid = out_v_r;
  assign out_ch.data  = out_data_r;

  assign sel_idx = (cursor_r == CUR_IDLE) ? field_idx_t'(0) : cursor_r - 3'd1;

  asm_bcd_cmp u_cmp (
    .item    (in_data_r),
    .fields  (fields_r),
    .time_eq (time_eq)
  );

  asm_field_step u_step (
    .idx (sel_idx),
    .up  (in_data_r.kind == KIND_INC),
    .cur (fields_r[sel_idx]),
    .nxt (step_val)
  );

  always_comb begin
    fields_nxt = fields_r;
    cursor_nxt = cursor_r;
    latch_nxt  = latch_r;
    matched    = 1'b0;
    case (in_data_r.kind)
      KIND_TIME: begin
        if (time_eq) begin
          matched   = 1'b1;
          latch_nxt = 1'b1;
        end
      end
      KIND_SELECT: begin
        cursor_nxt = cursor_r + 3'd1;
      end
      KIND_INC, KIND_DEC: begin
        if (cursor_r == CUR_IDLE) begin
          latch_nxt = 1'b0;
        end else begin
          fields_nxt[sel_idx] = step_val;
        end
      end
      default: begin
        fields_nxt = fields_r;
      end
    endcase
  end

  assign out_idx = (cursor_nxt == CUR_IDLE) ? field_idx_t'(0) : cursor_nxt - 3'd1;

  always_comb begin
    res_nxt.alarm_on     = latch_nxt;
    res_nxt.cursor_field = cursor_nxt;
    res_nxt.field_value  = (cursor_nxt == CUR_IDLE) ? '0 : fields_nxt[out_idx];
    res_nxt.time_matched = matched;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r   <= 1'b0;
      out_v_r  <= 1'b0;
      fields_r <= '0;
      cursor_r <= CUR_IDLE;
      latch_r  <= 1'b0;
    end else begin
      if (in_acc) begin
        in_v_r <= 1'b1;
      end else if (fire) begin
        in_v_r <= 1'b0;
      end
      if (fire) begin
        out_v_r  <= 1'b1;
        fields_r <= fields_nxt;
        cursor_r <= cursor_nxt;
        latch_r  <= latch_nxt;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_data_r <= in_ch.data;
    end
    if (fire) begin
      out_data_r <= res_nxt;
    end
  end

  // select beat steps the cursor by one, wrapping from second back to idle
  a_cursor_step: assert property (@(posedge clk) disable iff (!rst_n)
    fire && in_data_r.kind == KIND_SELECT |=> cursor_r == $past(cursor_r) + 3'd1)
    else $error("cursor did not advance on select");

  // a matching sample always leaves the alarm sounding
  a_match_sets_latch: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_data_r.time_matched |-> out_data_r.alarm_on)
    else $error("match reported without alarm latch set");

  // idle cursor shows no field value
  a_idle_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_data_r.cursor_field == CUR_IDLE |-> out_data_r.field_value == '0)
    else $error("nonzero field value while idle");

  // a press while editing never touches the latch
  a_edit_keeps_latch: assert property (@(posedge clk) disable iff (!rst_n)
    fire && in_data_r.kind != KIND_TIME && cursor_r != CUR_IDLE |=> $stable(latch_r))
    else $error("latch changed by edit press");

  for (genvar g = 0; g < FIELD_COUNT; g++) begin : g_range
    a_field_max: assert property (@(posedge clk) disable iff (!rst_n)
      fields_r[g] <= FIELD_MAX[g])
      else $error("alarm field above its maximum");
  end

endmodule
`default_nettype wire

### bench/testbench.sv
// Self-checking bench for the alarm set and match block: predicts and checks every result beat.
module testbench;
  import asm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    field_val_t fields [FIELD_COUNT];
    cursor_t    cursor;
    logic       latch;
  } alarm_state_t;

  logic clk;
  logic rst_n;

  asm_in_if  in_ch();
  asm_out_if out_ch();

  alarm_set_and_match_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  in_item_t     events_to_send [$];
  out_item_t    expected_status [$];
  alarm_state_t scored_alarm;
  alarm_state_t planned_alarm;

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int mismatches    = 0;
  int status_beats  = 0;
  int hold_left     = 0;
  bit hold_done     = 1'b0;

  always #6 clk = ~clk;

  function automatic field_val_t bcd_value(input logic [7:0] b);
    int v;
    v = int'(b[6:4]) * 10 + int'(b[3:0]);
    return field_val_t'(v);
  endfunction

  // Next state and result for one item; the state is updated in place.
  function automatic out_item_t alarm_advance(inout alarm_state_t s, input in_item_t it);
    out_item_t  r;
    field_val_t seen [FIELD_COUNT];
    logic       hit;
    int         idx;
    r = '0;
    case (it.kind)
      KIND_TIME: begin
        seen[0] = bcd_value(it.rtc_year_bcd);
        seen[1] = bcd_value(it.rtc_month_bcd);
        seen[2] = bcd_value(it.rtc_day_bcd);
        seen[3] = field_val_t'(it.rtc_weekday_raw[2:0]);
        seen[4] = bcd_value(it.rtc_hour_bcd);
        seen[5] = bcd_value(it.rtc_minute_bcd);
        seen[6] = bcd_value(it.rtc_second_bcd);
        hit = 1'b1;
        for (int i = 0; i < FIELD_COUNT; i++)
          if (seen[i] != s.fields[i]) hit = 1'b0;
        if (hit) begin
          s.latch = 1'b1;
          r.time_matched = 1'b1;
        end
      end
      KIND_SELECT: begin
        s.cursor = s.cursor + 3'd1;
      end
      default: begin
        if (s.cursor == CUR_IDLE) begin
          s.latch = 1'b0;
        end else begin
          idx = int'(s.cursor) - 1;
          if (it.kind == KIND_INC) begin
            if (s.fields[idx] >= FIELD_MAX[idx]) s.fields[idx] = FIELD_MIN[idx];
            else s.fields[idx] = s.fields[idx] + 7'd1;
          end else begin
            if (s.fields[idx] <= FIELD_MIN[idx]) s.fields[idx] = FIELD_MAX[idx];
            else s.fields[idx] = s.fields[idx] - 7'd1;
          end
        end
      end
    endcase
    r.alarm_on     = s.latch;
    r.cursor_field = s.cursor;
    r.field_value  = (s.cursor == CUR_IDLE) ? '0 : s.fields[int'(s.cursor) - 1];
    return r;
  endfunction

  function automatic in_item_t random_item();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[$bits(in_item_t)-1:0];
  endfunction

  function automatic in_item_t press(input kind_t k);
    in_item_t it;
    it = random_item();
    it.kind = k;
    return it;
  endfunction

  function automatic in_item_t time_item(input logic [7:0] y, mo, d, w, h, mi, s);
    in_item_t it;
    it.kind            = KIND_TIME;
    it.rtc_year_bcd    = y;
    it.rtc_month_bcd   = mo;
    it.rtc_day_bcd     = d;
    it.rtc_weekday_raw = w;
    it.rtc_hour_bcd    = h;
    it.rtc_minute_bcd  = mi;
    it.rtc_second_bcd  = s;
    return it;
  endfunction

  // Byte that decodes to v where possible, with a random top bit and alternate digit splits.
  function automatic logic [7:0] bcd_encode(input int v);
    int tens;
    int ones;
    tens = v / 10;
    ones = v % 10;
    if (tens > 7) begin
      ones = ones + (tens - 7) * 10;
      tens = 7;
    end else if (tens > 0 && ones <= 5 && $urandom_range(1) == 1) begin
      tens = tens - 1;
      ones = ones + 10;
    end
    return {1'($urandom), 3'(tens), 4'(ones)};
  endfunction

  function automatic in_item_t matching_sample(input alarm_state_t s);
    in_item_t it;
    it = time_item(bcd_encode(s.fields[0]), bcd_encode(s.fields[1]), bcd_encode(s.fields[2]),
                   {5'($urandom), s.fields[3][2:0]}, bcd_encode(s.fields[4]),
                   bcd_encode(s.fields[5]), bcd_encode(s.fields[6]));
    if ($urandom_range(3) == 0) begin
      case ($urandom_range(6))
        0: it.rtc_year_bcd    ^= 8'h01 << $urandom_range(6);
        1: it.rtc_month_bcd   ^= 8'h01 << $urandom_range(6);
        2: it.rtc_day_bcd     ^= 8'h01 << $urandom_range(6);
        3: it.rtc_weekday_raw ^= 8'h01 << $urandom_range(2);
        4: it.rtc_hour_bcd    ^= 8'h01 << $urandom_range(6);
        5: it.rtc_minute_bcd  ^= 8'h01 << $urandom_range(6);
        default: it.rtc_second_bcd ^= 8'h01 << $urandom_range(6);
      endcase
    end
    return it;
  endfunction

  task automatic queue_event(input in_item_t it);
    void'(alarm_advance(planned_alarm, it));
    events_to_send.push_back(it);
  endtask

  task automatic queue_random(input int n);
    int added;
    int pick;
    int reps;
    added = 0;
    while (added < n) begin
      pick = $urandom_range(99);
      if (pick < 35) begin
        queue_event(matching_sample(planned_alarm));
        added++;
      end else if (pick < 65) begin
        reps = $urandom_range(1, 3);
        for (int i = 0; i < reps; i++) queue_event(press(KIND_SELECT));
        reps = $urandom_range(1, 8);
        for (int i = 0; i < reps; i++)
          queue_event(press($urandom_range(1) ? KIND_INC : KIND_DEC));
        added += 2 + reps;
      end else if (pick < 78) begin
        queue_event(press(KIND_SELECT));
        added++;
      end else if (pick < 88) begin
        queue_event(press($urandom_range(1) ? KIND_INC : KIND_DEC));
        added++;
      end else begin
        queue_event(random_item());
        added++;
      end
    end
  endtask

  task automatic drain();
    while (events_to_send.size() != 0 || expected_status.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s expected %0d got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Sender: holds a beat until taken, predicts on acceptance.
  always @(posedge clk) begin
    logic held;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.data  <= '0;
    end else begin
      held = in_ch.valid && !in_ch.ready;
      if (in_ch.valid && in_ch.ready)
        expected_status.push_back(alarm_advance(scored_alarm, events_to_send.pop_front()));
      if (held) begin
      end else if (events_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_ch.valid <= 1'b1;
        in_ch.data  <= events_to_send[0];
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Long receiver hold, once, after the result stream is established.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (!hold_done && status_beats >= 150) begin
      hold_left <= 100;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Receiver: checks each result beat and drives backpressure.
  always @(posedge clk) begin
    out_item_t want;
    out_item_t got;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.data;
        status_beats++;
        if (expected_status.size() == 0) begin
          $error("result beat with nothing expected");
          mismatches++;
        end else begin
          want = expected_status.pop_front();
          check_field("alarm_on", want.alarm_on, got.alarm_on);
          check_field("cursor_field", want.cursor_field, got.cursor_field);
          check_field("field_value", want.field_value, got.field_value);
          check_field("time_matched", want.time_matched, got.time_matched);
        end
      end
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  initial begin
    #5ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    clk          = 1'b0;
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
    for (int i = 0; i < FIELD_COUNT; i++) begin
      scored_alarm.fields[i]  = '0;
      planned_alarm.fields[i] = '0;
    end
    scored_alarm.cursor  = CUR_IDLE;
    scored_alarm.latch   = 1'b0;
    planned_alarm.cursor = CUR_IDLE;
    planned_alarm.latch  = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed: idle presses, all-zero match, field wraps, compare while editing
    queue_event(press(KIND_DEC));
    queue_event(time_item(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    queue_event(time_item(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    queue_event(press(KIND_INC));
    queue_event(press(KIND_SELECT));
    queue_event(press(KIND_DEC));
    queue_event(press(KIND_INC));
    queue_event(press(KIND_SELECT));
    queue_event(press(KIND_DEC));
    queue_event(press(KIND_INC));
    queue_event(press(KIND_DEC));
    queue_event(press(KIND_SELECT));
    queue_event(press(KIND_INC));
    queue_event(press(KIND_DEC));
    queue_event(press(KIND_SELECT));
    queue_event(press(KIND_DEC));
    queue_event(press(KIND_INC));
    queue_event(press(KIND_SELECT));
    queue_event(press(KIND_DEC));
    queue_event(press(KIND_SELECT));
    queue_event(press(KIND_DEC));
    queue_event(press(KIND_SELECT));
    queue_event(press(KIND_DEC));
    queue_event(press(KIND_INC));
    queue_event(time_item(8'h80, 8'h12, 8'h31, 8'hF8, 8'hA3, 8'h59, 8'h80));
    queue_event(press(KIND_SELECT));
    queue_event(time_item(8'h00, 8'h12, 8'h31, 8'h07, 8'h23, 8'h59, 8'h00));
    drain();

    queue_random(240);
    drain();

    send_idle_pct = 74;
    stall_pct     = 0;
    queue_random(235);
    drain();

    send_idle_pct = 0;
    stall_pct     = 74;
    queue_random(235);
    drain();

    send_idle_pct = 37;
    stall_pct     = 37;
    queue_random(240);
    drain();

    repeat (8) @(posedge clk);
    if (expected_status.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
